FILE: hdl/msf_pkg.sv
// Shared constants, types and command codes of the multichannel ADC smoothing filter.
package msf_pkg;

  // Field and register widths
  localparam int SAMPLE_BITS = 12;
  localparam int CHANNEL_W   = 3;
  localparam int RATE_W      = 16;
  localparam int MV_SCALE_W  = 22;
  localparam int MV_W        = 16;
  localparam int FRAC_W      = 16;

  // Stream bus widths
  localparam int IN_TDATA_W  = 16;
  localparam int OUT_TDATA_W = 32;

  // Configuration port
  localparam int CFG_ADDR_W  = 3;
  localparam int CFG_DATA_W  = 22;

  localparam logic [CFG_ADDR_W-1:0] CFG_FILTER_MODE = 3'd0;
  localparam logic [CFG_ADDR_W-1:0] CFG_RATE_CH0    = 3'd1;
  localparam logic [CFG_ADDR_W-1:0] CFG_RATE_CH1    = 3'd2;
  localparam logic [CFG_ADDR_W-1:0] CFG_RATE_CH2    = 3'd3;
  localparam logic [CFG_ADDR_W-1:0] CFG_RATE_CH3    = 3'd4;
  localparam logic [CFG_ADDR_W-1:0] CFG_MV_SCALE    = 3'd5;

  // Register reset values
  localparam logic                  MODE_LOWPASS    = 1'b1;
  localparam logic                  MODE_MEAN       = 1'b0;
  localparam logic [RATE_W-1:0]     RATE_CH0_RST    = 16'd13107;
  localparam logic [RATE_W-1:0]     RATE_CHN_RST    = 16'd6554;
  localparam logic [MV_SCALE_W-1:0] MV_SCALE_RST    = 22'd52813;

  // Rate registers exist for the first four channels only
  localparam int RATE_REGS   = 4;
  localparam int RATE_IDX_W  = 2;

  // Shared multiplier operand and product widths
  localparam int MUL_A_W     = 17;
  localparam int MUL_B_W     = 22;
  localparam int MUL_P_W     = MUL_A_W + MUL_B_W;

  localparam logic [MUL_A_W-1:0] ONE_Q16 = 17'h10000;
  localparam logic [MV_W-1:0]    MV_MAX  = 16'hFFFF;

  // Parameter defaults
  localparam int CHANNELS_DEF    = 4;
  localparam int BLOCK_DEPTH_DEF = 4;

  // Datapath step selected by the controller
  typedef enum logic [2:0] {
    OP_NONE,
    OP_LP_OLD,
    OP_LP_NEW,
    OP_MEAN,
    OP_SCALE
  } msf_op_t;

  typedef struct packed {
    logic    load;
    msf_op_t op;
    logic    out_load;
  } msf_cmd_t;

  typedef struct packed {
    logic invalid;
    logic lowpass;
  } msf_status_t;

endpackage

FILE: hdl/msf_ctrl.sv
// Controller state machine: sequences the shared multiplier and the output register.
module msf_ctrl (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  output logic                  out_tvalid,
  input  logic                  out_tready,
  input  msf_pkg::msf_status_t  status,
  output msf_pkg::msf_cmd_t     cmd
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_LP_OLD,
    S_LP_NEW,
    S_MEAN,
    S_SCALE,
    S_DONE
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;

  // Next state and datapath commands
  always_comb begin
    state_nxt     = state_r;
    out_valid_nxt = out_valid_r && !out_tready;
    cmd           = '0;
    cmd.op        = msf_pkg::OP_NONE;
    case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          cmd.load = 1'b1;
          if (status.invalid) begin
            state_nxt = S_SCALE;
          end else if (status.lowpass) begin
            state_nxt = S_LP_OLD;
          end else begin
            state_nxt = S_MEAN;
          end
        end
      end
      S_LP_OLD: begin
        cmd.op    = msf_pkg::OP_LP_OLD;
        state_nxt = S_LP_NEW;
      end
      S_LP_NEW: begin
        cmd.op    = msf_pkg::OP_LP_NEW;
        state_nxt = S_SCALE;
      end
      S_MEAN: begin
        cmd.op    = msf_pkg::OP_MEAN;
        state_nxt = S_SCALE;
      end
      S_SCALE: begin
        cmd.op    = msf_pkg::OP_SCALE;
        state_nxt = S_DONE;
      end
      S_DONE: begin
        // Hand the result over once the output register is free
        if (!out_valid_r || out_tready) begin
          cmd.out_load  = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Hold state and output valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = out_valid_r;

  // One item at a time: after a transfer in, the input stays closed
  a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("input accepted while an item is in progress");

  // Never overwrite a result that is still waiting
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.out_load |-> !out_valid_r || out_tready)
    else $error("output register overwritten before transfer");

  // A result appears only when an item finishes
  a_valid_source: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == S_DONE))
    else $error("output valid raised outside the finishing step");

endmodule

FILE: hdl/msf_dp.sv
// Datapath: configuration registers, channel state, shared multiplier and output register.
module msf_dp #(
  parameter int CHANNELS    = msf_pkg::CHANNELS_DEF,
  parameter int BLOCK_DEPTH = msf_pkg::BLOCK_DEPTH_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             cfg_we,
  input  logic [msf_pkg::CFG_ADDR_W-1:0]   cfg_addr,
  input  logic [msf_pkg::CFG_DATA_W-1:0]   cfg_data,
  input  logic [msf_pkg::CHANNEL_W-1:0]    in_channel,
  input  logic [msf_pkg::SAMPLE_BITS-1:0]  in_sample,
  input  msf_pkg::msf_cmd_t                cmd,
  output msf_pkg::msf_status_t             status,
  output logic [msf_pkg::CHANNEL_W-1:0]    out_channel,
  output logic [msf_pkg::SAMPLE_BITS-1:0]  out_filtered,
  output logic [msf_pkg::MV_W-1:0]         out_millivolts
);

  localparam int SB     = msf_pkg::SAMPLE_BITS;
  localparam int IDX_W  = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int CNT_W  = (BLOCK_DEPTH > 1) ? $clog2(BLOCK_DEPTH) : 1;
  localparam int SUM_W  = $clog2(BLOCK_DEPTH * ((1 << SB) - 1) + 1);
  localparam int DIV_SH = $clog2(BLOCK_DEPTH);
  localparam int Q_SH   = SUM_W + DIV_SH;
  // Reciprocal of the block depth: exact floor division for any SUM_W-bit sum
  localparam logic [63:0] RECIP_FULL =
    ((64'd1 << Q_SH) + 64'(BLOCK_DEPTH) - 64'd1) / 64'(BLOCK_DEPTH);
  localparam logic [msf_pkg::MUL_B_W-1:0] RECIP = RECIP_FULL[msf_pkg::MUL_B_W-1:0];
  localparam logic [msf_pkg::CHANNEL_W:0] CH_LIM   = (msf_pkg::CHANNEL_W + 1)'(CHANNELS);
  localparam logic [msf_pkg::CHANNEL_W:0] RATE_LIM = (msf_pkg::CHANNEL_W + 1)'(msf_pkg::RATE_REGS);
  localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(BLOCK_DEPTH - 1);

  // Configuration registers
  logic                              mode_r;
  logic [msf_pkg::RATE_W-1:0]        rate_cfg_r [msf_pkg::RATE_REGS];
  logic [msf_pkg::MV_SCALE_W-1:0]    mv_scale_r;

  // Per-channel state
  logic [SB-1:0]    filt_r [CHANNELS];
  logic [SUM_W-1:0] msum_r [CHANNELS];
  logic [CNT_W-1:0] mcnt_r [CHANNELS];

  // Working registers of the item in progress
  logic [msf_pkg::CHANNEL_W-1:0] ch_r;
  logic [SB-1:0]                 x_r;
  logic [SB-1:0]                 y_r;
  logic [SUM_W-1:0]              sum_r;
  logic [CNT_W-1:0]              cnt_r;
  logic [msf_pkg::RATE_W-1:0]    rate_r;
  logic                          lp_r;
  logic                          inv_r;
  logic [msf_pkg::MUL_P_W-1:0]   prod_r;

  // Output register
  logic [msf_pkg::CHANNEL_W-1:0] out_ch_r;
  logic [SB-1:0]                 out_filt_r;
  logic [msf_pkg::MV_W-1:0]      out_mv_r;

  logic                          in_valid_ch;
  logic                          in_has_rate;
  logic [IDX_W-1:0]              in_idx;
  logic [IDX_W-1:0]              idx;
  logic [msf_pkg::MUL_A_W-1:0]   mul_a;
  logic [msf_pkg::MUL_B_W-1:0]   mul_b;
  logic                          mul_acc;
  logic [msf_pkg::MUL_P_W-1:0]   mul_p;
  logic                          block_full;
  logic [SB-1:0]                 y_src;
  logic [msf_pkg::MV_W-1:0]      mv_sat;

  assign in_valid_ch = ({1'b0, in_channel} < CH_LIM);
  assign in_has_rate = ({1'b0, in_channel} < RATE_LIM);
  assign in_idx      = in_channel[IDX_W-1:0];
  assign idx         = ch_r[IDX_W-1:0];

  assign status.invalid = !in_valid_ch;
  assign status.lowpass = (mode_r == msf_pkg::MODE_LOWPASS);

  // Write configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r        <= msf_pkg::MODE_LOWPASS;
      rate_cfg_r[0] <= msf_pkg::RATE_CH0_RST;
      rate_cfg_r[1] <= msf_pkg::RATE_CHN_RST;
      rate_cfg_r[2] <= msf_pkg::RATE_CHN_RST;
      rate_cfg_r[3] <= msf_pkg::RATE_CHN_RST;
      mv_scale_r    <= msf_pkg::MV_SCALE_RST;
    end else if (cfg_we) begin
      case (cfg_addr)
        msf_pkg::CFG_FILTER_MODE: mode_r        <= cfg_data[0];
        msf_pkg::CFG_RATE_CH0:    rate_cfg_r[0] <= cfg_data[msf_pkg::RATE_W-1:0];
        msf_pkg::CFG_RATE_CH1:    rate_cfg_r[1] <= cfg_data[msf_pkg::RATE_W-1:0];
        msf_pkg::CFG_RATE_CH2:    rate_cfg_r[2] <= cfg_data[msf_pkg::RATE_W-1:0];
        msf_pkg::CFG_RATE_CH3:    rate_cfg_r[3] <= cfg_data[msf_pkg::RATE_W-1:0];
        msf_pkg::CFG_MV_SCALE:    mv_scale_r    <= cfg_data[msf_pkg::MV_SCALE_W-1:0];
        default: ;
      endcase
    end
  end

  // Block mean completes on the last sample of a block
  assign block_full = (cnt_r == CNT_LAST);

  // Filtered value of this item, valid during the scale step
  always_comb begin
    if (inv_r) begin
      y_src = y_r;
    end else if (lp_r) begin
      y_src = prod_r[msf_pkg::FRAC_W +: SB];
    end else if (block_full) begin
      y_src = prod_r[Q_SH +: SB];
    end else begin
      y_src = y_r;
    end
  end

  // Select multiplier operands for the current step
  always_comb begin
    mul_a   = '0;
    mul_b   = '0;
    mul_acc = 1'b0;
    case (cmd.op)
      msf_pkg::OP_LP_OLD: begin
        mul_a = msf_pkg::ONE_Q16 - msf_pkg::MUL_A_W'(rate_r);
        mul_b = msf_pkg::MUL_B_W'(y_r);
      end
      msf_pkg::OP_LP_NEW: begin
        mul_a   = msf_pkg::MUL_A_W'(rate_r);
        mul_b   = msf_pkg::MUL_B_W'(x_r);
        mul_acc = 1'b1;
      end
      msf_pkg::OP_MEAN: begin
        mul_a = msf_pkg::MUL_A_W'(sum_r);
        mul_b = RECIP;
      end
      msf_pkg::OP_SCALE: begin
        mul_a = msf_pkg::MUL_A_W'(y_src);
        mul_b = mv_scale_r;
      end
      default: ;
    endcase
  end

  assign mul_p = msf_pkg::MUL_P_W'(mul_a) * msf_pkg::MUL_P_W'(mul_b)
               + (mul_acc ? prod_r : '0);

  // Load the item, run the multiplier and keep working values
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      ch_r  <= in_channel;
      x_r   <= in_sample;
      inv_r <= !in_valid_ch;
      lp_r  <= (mode_r == msf_pkg::MODE_LOWPASS);
      y_r   <= in_valid_ch ? filt_r[in_idx] : '0;
      sum_r <= in_valid_ch ? msum_r[in_idx] + SUM_W'(in_sample) : '0;
      cnt_r <= in_valid_ch ? mcnt_r[in_idx] : '0;
      rate_r <= (in_valid_ch && in_has_rate) ?
                rate_cfg_r[in_channel[msf_pkg::RATE_IDX_W-1:0]] : '0;
    end
    if (cmd.op != msf_pkg::OP_NONE) begin
      prod_r <= mul_p;
    end
    if (cmd.op == msf_pkg::OP_SCALE) begin
      y_r <= y_src;
    end
  end

  // Commit the channel state at the scale step
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < CHANNELS; i++) begin
        filt_r[i] <= '0;
        msum_r[i] <= '0;
        mcnt_r[i] <= '0;
      end
    end else if (cmd.op == msf_pkg::OP_SCALE && !inv_r) begin
      filt_r[idx] <= y_src;
      if (!lp_r) begin
        if (block_full) begin
          msum_r[idx] <= '0;
          mcnt_r[idx] <= '0;
        end else begin
          msum_r[idx] <= sum_r;
          mcnt_r[idx] <= cnt_r + CNT_W'(1);
        end
      end
    end
  end

  // Saturate the millivolt product
  assign mv_sat = (|prod_r[msf_pkg::MUL_P_W-1:msf_pkg::FRAC_W+msf_pkg::MV_W]) ?
                  msf_pkg::MV_MAX : prod_r[msf_pkg::FRAC_W +: msf_pkg::MV_W];

  // Output register
  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_ch_r   <= ch_r;
      out_filt_r <= y_r;
      out_mv_r   <= mv_sat;
    end
  end

  assign out_channel    = out_ch_r;
  assign out_filtered   = out_filt_r;
  assign out_millivolts = out_mv_r;

  // An invalid channel reports zeros
  a_invalid_zero: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.out_load && inv_r |=> out_filtered == '0 && out_millivolts == '0)
    else $error("invalid channel produced a nonzero result");

  // The low pass never overshoots its two inputs
  a_lp_bounded: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.op == msf_pkg::OP_SCALE && lp_r && !inv_r |->
      (y_src <= y_r) || (y_src <= x_r))
    else $error("low pass result outside of old value and sample");

  // A loaded block count is always short of a full block
  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load |=> cnt_r <= CNT_LAST)
    else $error("mean block count out of range");

endmodule

FILE: hdl/multichannel_adc_smoothing_filter.sv
// Top level of the multichannel ADC smoothing filter: controller, datapath and ports.
//
// Usage:
//   Input stream: one ADC sample per transfer, in_tdata[11:0] the sample and
//   in_tuser[2:0] its channel. Output stream: one result per input transfer,
//   in the same order, out_tuser[2:0] the channel echoed, out_tdata[11:0] the
//   channel's filtered value and out_tdata[27:12] that value in millivolts.
//   Configuration: write cfg_data to register cfg_addr while cfg_we is high;
//   write only while no item is in progress.
// Sequencing:
//   One shared 17x22 multiplier does all products, so an item occupies it for
//   one to three steps: old value and new sample, then scale, in low pass mode;
//   mean, then scale, in mean mode; scale alone for a channel without state.
//   out_tvalid rises once the item finishes and the output register is free.
//   The next sample is accepted only after the item has finished.
// Reset (rst_n low, synchronous): registers take their defaults, all channel
//   values, sums and counts clear, and the output stream goes empty.
// Stall: a finished result waits in the output register; the next sample is
//   accepted and worked on meanwhile, and its result waits until the
//   register is taken.
module multichannel_adc_smoothing_filter #(
  parameter int CHANNELS    = msf_pkg::CHANNELS_DEF,
  parameter int BLOCK_DEPTH = msf_pkg::BLOCK_DEPTH_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              cfg_we,
  input  logic [msf_pkg::CFG_ADDR_W-1:0]    cfg_addr,
  input  logic [msf_pkg::CFG_DATA_W-1:0]    cfg_data,
  input  logic                              in_tvalid,
  output logic                              in_tready,
  input  logic [msf_pkg::IN_TDATA_W-1:0]    in_tdata,   // [11:0] sample, [15:12] zero
  input  logic [msf_pkg::CHANNEL_W-1:0]     in_tuser,   // [2:0] channel
  output logic                              out_tvalid,
  input  logic                              out_tready,
  output logic [msf_pkg::OUT_TDATA_W-1:0]   out_tdata,  // [11:0] filtered, [27:12] millivolts,
                                                        // [31:28] zero
  output logic [msf_pkg::CHANNEL_W-1:0]     out_tuser   // [2:0] out_channel
);

  localparam int SB     = msf_pkg::SAMPLE_BITS;
  localparam int PAD_W  = msf_pkg::OUT_TDATA_W - SB - msf_pkg::MV_W;

  msf_pkg::msf_cmd_t    cmd;
  msf_pkg::msf_status_t status;

  logic [SB-1:0]              filtered;
  logic [msf_pkg::MV_W-1:0]   millivolts;

  msf_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .status     (status),
    .cmd        (cmd)
  );

  msf_dp #(
    .CHANNELS    (CHANNELS),
    .BLOCK_DEPTH (BLOCK_DEPTH)
  ) u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_we         (cfg_we),
    .cfg_addr       (cfg_addr),
    .cfg_data       (cfg_data),
    .in_channel     (in_tuser),
    .in_sample      (in_tdata[SB-1:0]),
    .cmd            (cmd),
    .status         (status),
    .out_channel    (out_tuser),
    .out_filtered   (filtered),
    .out_millivolts (millivolts)
  );

  // Pack the result fields, lowest first
  assign out_tdata = {{PAD_W{1'b0}}, millivolts, filtered};

endmodule
